FILE: hdl/websocket_frame_deframer_top_macros.svh
// Assertion macros shared by the frame deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Checks that a condition holds at every clock edge outside reset.
`define WSFD_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("deframer assertion failed");
// Checks that a trigger is followed by a condition in the next cycle.
`define WSFD_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("deframer assertion failed");
`else
`define WSFD_ASSERT(label, clk, rst, cond)
`define WSFD_ASSERT_NEXT(label, clk, rst, trig, cond)
`endif

`endif

FILE: hdl/wsfd_pkg.sv
// Types and constants of the frame deframer.
`default_nettype none
package wsfd_pkg;

   // Parser phases; codes 5 to 7 act as the first header byte phase.
   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;
   localparam logic [2:0] EXT_COUNT_16 = 3'd1;
   localparam logic [2:0] EXT_COUNT_64 = 3'd7;
   localparam logic [2:0] KEY_COUNT = 3'd3;

   // One result word.
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       frame_final;
      logic [3:0] frame_opcode;
      logic       last_of_frame;
      logic       empty_frame;
   } result_type;

endpackage
`default_nettype wire

FILE: hdl/websocket_frame_deframer_top.sv
// Top level of the WebSocket frame deframer.
// Header, length and key bytes give no word; a zero length gives one empty word.
// Throughput: one byte per cycle until the two-entry output buffer is full.
// Each payload byte gives one word, registered in the output buffer.
// Synchronous active-high reset returns the parser to the first header byte.
`include "websocket_frame_deframer_top_macros.svh"
`default_nettype none
module websocket_frame_deframer_top #(
   parameter int LENGTH_BITS = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_stream_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_frame_final,
   output logic [3:0]      rsp_frame_opcode,
   output logic            rsp_last_of_frame,
   output logic            rsp_empty_frame
);
   import wsfd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic                   final_ff, final_in;
   logic [3:0]             opcode_ff, opcode_in;
   logic                   masked_ff, masked_in;
   logic [2:0]             hdr_count_ff, hdr_count_in;
   logic [LENGTH_BITS-1:0] remain_ff, remain_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             key_pos_ff, key_pos_in;

   logic       req_fire;
   logic       res_valid;
   result_type res_data;
   result_type out_data;
   logic [7:0] key_byte;
   logic       hdr_done;

   assign req_fire = req_valid && req_ready;
   assign key_byte = key_ff[{~key_pos_ff, 3'b000} +: 8];

   // Parser next state and the result word for the accepted byte.
   always_comb begin
      phase_in     = phase_ff;
      final_in     = final_ff;
      opcode_in    = opcode_ff;
      masked_in    = masked_ff;
      hdr_count_in = hdr_count_ff;
      remain_in    = remain_ff;
      key_in       = key_ff;
      key_pos_in   = key_pos_ff;
      hdr_done     = 1'b0;
      res_valid    = 1'b0;
      res_data.payload_byte  = 8'd0;
      res_data.frame_final   = final_ff;
      res_data.frame_opcode  = opcode_ff;
      res_data.last_of_frame = 1'b1;
      res_data.empty_frame   = 1'b1;
      if (req_fire) begin
         case (phase_ff)
            PH_HDR1: begin
               masked_in = req_stream_byte[7];
               key_in    = 32'd0;
               remain_in = '0;
               if (req_stream_byte[6:0] == LEN_CODE_16) begin
                  phase_in     = PH_EXT;
                  hdr_count_in = EXT_COUNT_16;
               end else if (req_stream_byte[6:0] == LEN_CODE_64) begin
                  phase_in     = PH_EXT;
                  hdr_count_in = EXT_COUNT_64;
               end else begin
                  remain_in = LENGTH_BITS'(req_stream_byte[6:0]);
                  if (req_stream_byte[7]) begin
                     phase_in     = PH_KEY;
                     hdr_count_in = KEY_COUNT;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_EXT: begin
               // Lengths that overflow the counter saturate at all ones.
               if (remain_ff[LENGTH_BITS-1 -: 8] != 8'd0) begin
                  remain_in = '1;
               end else begin
                  remain_in = {remain_ff[LENGTH_BITS-9:0], req_stream_byte};
               end
               if (hdr_count_ff == 3'd0) begin
                  if (masked_ff) begin
                     phase_in     = PH_KEY;
                     hdr_count_in = KEY_COUNT;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end else begin
                  hdr_count_in = hdr_count_ff - 3'd1;
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], req_stream_byte};
               if (hdr_count_ff == 3'd0) begin
                  hdr_done = 1'b1;
               end else begin
                  hdr_count_in = hdr_count_ff - 3'd1;
               end
            end
            PH_DATA: begin
               res_valid = 1'b1;
               res_data.payload_byte  = req_stream_byte ^ key_byte;
               res_data.last_of_frame = (remain_ff == LENGTH_BITS'(1));
               res_data.empty_frame   = 1'b0;
               key_pos_in = key_pos_ff + 2'd1;
               remain_in  = remain_ff - LENGTH_BITS'(1);
               if (remain_in == '0) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               final_in  = req_stream_byte[7];
               opcode_in = req_stream_byte[3:0];
               phase_in  = PH_HDR1;
            end
         endcase
         // End of header: a zero length gives one empty word at once.
         if (hdr_done) begin
            key_pos_in = 2'd0;
            if (remain_in == '0) begin
               res_valid = 1'b1;
               phase_in  = PH_HDR0;
            end else begin
               phase_in = PH_DATA;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         final_ff     <= 1'b0;
         opcode_ff    <= 4'd0;
         masked_ff    <= 1'b0;
         hdr_count_ff <= 3'd0;
         remain_ff    <= '0;
         key_ff       <= 32'd0;
         key_pos_ff   <= 2'd0;
      end else begin
         phase_ff     <= phase_in;
         final_ff     <= final_in;
         opcode_ff    <= opcode_in;
         masked_ff    <= masked_in;
         hdr_count_ff <= hdr_count_in;
         remain_ff    <= remain_in;
         key_ff       <= key_in;
         key_pos_ff   <= key_pos_in;
      end
   end

   // Output buffer between the parser and the result channel.
   wsfd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_ready (rsp_ready)
   );

   assign rsp_payload_byte  = out_data.payload_byte;
   assign rsp_frame_final   = out_data.frame_final;
   assign rsp_frame_opcode  = out_data.frame_opcode;
   assign rsp_last_of_frame = out_data.last_of_frame;
   assign rsp_empty_frame   = out_data.empty_frame;

   `WSFD_ASSERT(a_data_has_length, clock, reset, phase_ff != PH_DATA || remain_ff != '0)
   `WSFD_ASSERT(a_key_only_masked, clock, reset, phase_ff != PH_KEY || masked_ff)

endmodule
`default_nettype wire

FILE: hdl/wsfd_skid.sv
// Two-entry output buffer that parts the parser from the result channel.
`include "websocket_frame_deframer_top_macros.svh"
`default_nettype none
module wsfd_skid (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire wsfd_pkg::result_type in_data,
   output logic                      in_ready,
   output logic                      out_valid,
   output wsfd_pkg::result_type      out_data,
   input  wire logic                 out_ready
);
   import wsfd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   // The output word refills from the skid entry first, then from a new word.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = in_data;
            out_valid_in = in_valid;
         end
      end else if (in_valid) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   `WSFD_ASSERT(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff)
   `WSFD_ASSERT_NEXT(a_skid_catches, clock, reset,
      in_valid && out_valid_ff && !out_ready, skid_valid_ff)
   `WSFD_ASSERT_NEXT(a_skid_drains, clock, reset,
      skid_valid_ff && out_valid_ff && out_ready, !skid_valid_ff && out_valid_ff)

endmodule
`default_nettype wire

FILE: dv/tb_websocket_frame_deframer_top.sv
// Self-checking testbench for the WebSocket frame deframer: directed table, random frames.
module tb_websocket_frame_deframer_top;
   import wsfd_pkg::*;

   localparam int LEN_BITS = 64;
   localparam logic [63:0] LEN_ALL = (LEN_BITS >= 64) ? '1 : ((64'd1 << LEN_BITS) - 64'd1);
   localparam int STREAM_BYTES = 1600;
   localparam int HOLD_CYCLES = 64;
   localparam int DIR_ROWS = 25;

   // Length forms of the second header byte.
   localparam int FORM_SHORT = 0;
   localparam int FORM_EXT16 = 1;
   localparam int FORM_EXT64 = 2;

   // One stream word with an optional typed expectation.
   typedef struct {
      logic [7:0] data;
      bit         fixed;
      bit         want;
      result_type word;
   } stream_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_stream_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_frame_final;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_last_of_frame;
   logic       rsp_empty_frame;

   websocket_frame_deframer_top #(.LENGTH_BITS(LEN_BITS)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_stream_byte   (req_stream_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_frame_final   (rsp_frame_final),
      .rsp_frame_opcode  (rsp_frame_opcode),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_empty_frame   (rsp_empty_frame)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Parser state of the predictor.
   phase_type   ps_phase = PH_HDR0;
   logic        ps_final = 1'b0;
   logic [3:0]  ps_opcode = 4'h0;
   logic        ps_masked = 1'b0;
   logic [2:0]  ps_count = 3'd0;
   logic [63:0] ps_len = 64'd0;
   logic [31:0] ps_key = 32'd0;
   logic [1:0]  ps_pos = 2'd0;

   stream_row_type stream_q[$];
   result_type     pending_words[$];
   stream_row_type dir_table [DIR_ROWS];

   int send_idx = 0;
   int tail_start = 0;
   int gap_left = 0;
   int tx_pct = 0;
   int rx_gap = 0;
   int rx_pct = 0;
   int rx_tick = 0;
   int words_checked = 0;
   int frames_done = 0;
   int empties_seen = 0;
   int input_stalls = 0;
   int fail_count = 0;
   logic calm = 1'b0;
   logic hold_off = 1'b0;
   bit offer;
   bit made;
   stream_row_type row;
   result_type predicted;
   result_type got;
   result_type wanted;

   // The frame header is complete: give the empty-frame word or move to payload.
   task automatic finish_header(output bit has_word, output result_type w);
      ps_pos = 2'd0;
      if (ps_len == 64'd0) begin
         w = {8'h00, ps_final, ps_opcode, 1'b1, 1'b1};
         has_word = 1'b1;
         ps_phase = PH_HDR0;
      end else begin
         ps_phase = PH_DATA;
      end
   endtask

   // The length is known: read the mask key only when the mask bit is set.
   task automatic finish_length(output bit has_word, output result_type w);
      if (ps_masked) begin
         ps_phase = PH_KEY;
         ps_count = KEY_COUNT;
      end else begin
         finish_header(has_word, w);
      end
   endtask

   // Advance the parser by one stream byte and give the word it causes, if any.
   task automatic deframe_byte(input logic [7:0] b, output bit has_word, output result_type w);
      logic [7:0] key_byte;
      has_word = 1'b0;
      w = '0;
      case (ps_phase)
         PH_HDR1: begin
            ps_masked = b[7];
            ps_key = 32'd0;
            ps_len = 64'd0;
            if (b[6:0] == LEN_CODE_16) begin
               ps_phase = PH_EXT;
               ps_count = EXT_COUNT_16;
            end else if (b[6:0] == LEN_CODE_64) begin
               ps_phase = PH_EXT;
               ps_count = EXT_COUNT_64;
            end else begin
               ps_len = {57'd0, b[6:0]};
               finish_length(has_word, w);
            end
         end
         PH_EXT: begin
            // Lengths too wide for the counter saturate.
            if ((ps_len >> (LEN_BITS - 8)) != 64'd0) ps_len = LEN_ALL;
            else ps_len = ((ps_len << 8) | {56'd0, b}) & LEN_ALL;
            if (ps_count == 3'd0) finish_length(has_word, w);
            else ps_count = ps_count - 3'd1;
         end
         PH_KEY: begin
            ps_key = {ps_key[23:0], b};
            if (ps_count == 3'd0) finish_header(has_word, w);
            else ps_count = ps_count - 3'd1;
         end
         PH_DATA: begin
            key_byte = ps_key[8 * (3 - ps_pos) +: 8];
            w = {b ^ key_byte, ps_final, ps_opcode, ps_len == 64'd1, 1'b0};
            has_word = 1'b1;
            ps_pos = ps_pos + 2'd1;
            ps_len = (ps_len - 64'd1) & LEN_ALL;
            if (w.last_of_frame || ps_len == 64'd0) ps_phase = PH_HDR0;
         end
         default: begin
            ps_final = b[7];
            ps_opcode = b[3:0];
            ps_phase = PH_HDR1;
         end
      endcase
   endtask

   task automatic push_byte(input logic [7:0] data);
      stream_row_type r;
      r.data = data;
      r.fixed = 1'b0;
      r.want = 1'b0;
      r.word = '0;
      stream_q.insert(stream_q.size(), r);
   endtask

   // Append one frame; body may be shorter than len for the last frame of the run.
   task automatic add_frame(input logic [7:0] head, input bit masked, input int form,
                            input logic [63:0] len, input int body);
      push_byte(head);
      case (form)
         FORM_EXT16: begin
            push_byte({masked, LEN_CODE_16});
            push_byte(len[15:8]);
            push_byte(len[7:0]);
         end
         FORM_EXT64: begin
            push_byte({masked, LEN_CODE_64});
            for (int i = 7; i >= 0; i--) push_byte(len[8 * i +: 8]);
         end
         default: push_byte({masked, len[6:0]});
      endcase
      if (masked) repeat (4) push_byte(8'($urandom_range(0, 255)));
      repeat (body) push_byte(8'($urandom_range(0, 255)));
   endtask

   // Mostly short frames, some extended forms, an empty frame now and then.
   task automatic add_random_frame();
      logic [63:0] len;
      int form;
      int pick;
      bit masked;
      masked = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         form = FORM_SHORT;
         pick = $urandom_range(0, 99);
         if (pick < 10) len = 64'd0;
         else if (pick < 85) len = 64'($urandom_range(1, 10));
         else len = 64'($urandom_range(11, 125));
      end else if (pick < 85) begin
         form = FORM_EXT16;
         len = ($urandom_range(0, 9) == 0) ? 64'd0 : 64'($urandom_range(1, 200));
      end else begin
         form = FORM_EXT64;
         len = ($urandom_range(0, 9) == 0) ? 64'd0 : 64'($urandom_range(1, 160));
      end
      add_frame(8'($urandom_range(0, 255)), masked, form, len, int'(len));
   endtask

   // Build the whole stream before reset is released.
   initial begin
      dir_table = '{
         // Header byte right after reset gives no word.
         '{8'h81, 1'b1, 1'b0, '0},
         // Unmasked frame of length zero.
         '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 4'h1, 1'b1, 1'b1}},
         // Masked two-byte frame, opcode 15, fin clear.
         '{8'h0F, 1'b1, 1'b0, '0},
         '{8'h82, 1'b1, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b0, '0},
         '{8'h00, 1'b0, 1'b0, '0},
         '{8'hAA, 1'b0, 1'b0, '0},
         '{8'h55, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 4'hF, 1'b0, 1'b0}},
         '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 4'hF, 1'b1, 1'b0}},
         // Reserved bits set, 16-bit length form carrying a small value.
         '{8'hF0, 1'b0, 1'b0, '0},
         '{8'h7E, 1'b0, 1'b0, '0},
         '{8'h00, 1'b0, 1'b0, '0},
         '{8'h01, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b0, '0},
         // 64-bit length form of zero gives the empty word on its last byte.
         '{8'h89, 1'b0, 1'b0, '0},
         '{8'h7F, 1'b0, 1'b0, '0},
         '{8'h00, 1'b0, 1'b0, '0},
         '{8'h00, 1'b0, 1'b0, '0},
         '{8'h00, 1'b0, 1'b0, '0},
         '{8'h00, 1'b0, 1'b0, '0},
         '{8'h00, 1'b0, 1'b0, '0},
         '{8'h00, 1'b0, 1'b0, '0},
         '{8'h00, 1'b0, 1'b0, '0},
         '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 4'h9, 1'b1, 1'b1}}
      };
      for (int i = 0; i < DIR_ROWS; i++) stream_q.insert(stream_q.size(), dir_table[i]);
      while (stream_q.size() < STREAM_BYTES) add_random_frame();
      // A huge 64-bit length closes the run; only its first bytes are sent.
      add_frame(8'h02, 1'b1, FORM_EXT64,
                {$urandom(), $urandom()} | 64'h8000_0000_0000_0000, 24);
      tail_start = stream_q.size() * 85 / 100;
   end

   // Sender: offers stream words, predicts on every accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            row = stream_q[send_idx];
            deframe_byte(row.data, made, predicted);
            if (row.fixed) begin
               if (row.want) pending_words.insert(pending_words.size(), row.word);
            end else if (made) begin
               pending_words.insert(pending_words.size(), predicted);
            end
            send_idx++;
            offer = 1'b0;
            if (send_idx % 150 == 0) begin
               case ($urandom_range(0, 2))
                  0: tx_pct = 0;
                  1: tx_pct = 10;
                  default: tx_pct = 35;
               endcase
            end
         end
         if (!offer && send_idx < stream_q.size()) begin
            if (gap_left > 0 && !calm) gap_left--;
            else if (!calm && !hold_off && $urandom_range(0, 99) < tx_pct)
               gap_left = $urandom_range(0, 6);
            else offer = 1'b1;
         end
         req_valid <= offer;
         if (offer) req_stream_byte <= stream_q[send_idx].data;
         calm <= (send_idx >= tail_start);
      end
   end

   // Receiver: random stall bursts, none in the tail of the run.
   always @(posedge clock) begin
      rx_tick++;
      if (rx_tick % 200 == 0) begin
         case ($urandom_range(0, 2))
            0: rx_pct = 0;
            1: rx_pct = 10;
            default: rx_pct = 35;
         endcase
      end
      if (reset || hold_off) begin
         rsp_ready <= 1'b0;
      end else if (rx_gap > 0 && !calm) begin
         rx_gap--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rx_pct) begin
         rx_gap = $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Long receiver hold-offs so that the output buffer fills and stalls the input.
   initial begin
      for (int h = 0; h < 2; h++) begin
         while (words_checked < 250 + 350 * h) @(posedge clock);
         hold_off <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_off <= 1'b0;
      end
   end

   // Compare each accepted word with the oldest predicted one.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_ready) input_stalls++;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_payload_byte, rsp_frame_final, rsp_frame_opcode,
                rsp_last_of_frame, rsp_empty_frame};
         words_checked++;
         if (got.last_of_frame === 1'b1) frames_done++;
         if (got.empty_frame === 1'b1) empties_seen++;
         if (pending_words.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display({"word %0d arrived with nothing predicted:",
                         " byte %h fin %b op %h last %b empty %b"},
                        words_checked, got.payload_byte, got.frame_final, got.frame_opcode,
                        got.last_of_frame, got.empty_frame);
         end else begin
            wanted = pending_words.pop_front();
            if (got !== wanted) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"word %0d mismatch: expected byte %h fin %b op %h last %b empty %b,",
                            " got byte %h fin %b op %h last %b empty %b"},
                           words_checked, wanted.payload_byte, wanted.frame_final,
                           wanted.frame_opcode, wanted.last_of_frame, wanted.empty_frame,
                           got.payload_byte, got.frame_final, got.frame_opcode,
                           got.last_of_frame, got.empty_frame);
            end
         end
      end
   end

   // Reset, run the stream, drain, report.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (send_idx < stream_q.size()) @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_words.size() != 0) begin
         fail_count += pending_words.size();
         $display("%0d predicted words never arrived", pending_words.size());
      end
      $display("Fed %0d stream bytes; checked %0d words over %0d frame ends, %0d empty.",
               send_idx, words_checked, frames_done, empties_seen);
      $display("The input side was held off for %0d cycles by output back-pressure.",
               input_stalls);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5000000;
      $display("tb: failure");
      $finish;
   end

endmodule
